/* hw/rtl/sbit_pkg.sv */
// Shared widths, register indexes and pipeline word type for the segment/box test.
package sbit_pkg;

  // Field widths
  localparam int COORD_W   = 19;
  localparam int BOX_W     = 13;
  localparam int FRAC_MAX  = 8;
  localparam int EDGE_W    = BOX_W + FRAC_MAX;
  // Slab offsets (q) cover a signed coordinate minus a scaled edge at the widest fraction
  localparam int QW        = ((COORD_W > EDGE_W + 1) ? COORD_W : EDGE_W + 1) + 1;
  // Segment deltas and their magnitudes
  localparam int DW        = COORD_W + 1;
  localparam int MW        = COORD_W;
  // Cross products of a ratio numerator with a denominator
  localparam int PW        = QW + MW;

  // One clip step per rectangle side, two register stages per step, one setup stage
  localparam int STEPS     = 4;
  localparam int LATENCY   = 1 + 2 * STEPS;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP    = CFG_IDX_W'(3);

  // Clip side handled by a step, in processing order
  localparam int unsigned SIDE_LEFT   = 0;
  localparam int unsigned SIDE_RIGHT  = 1;
  localparam int unsigned SIDE_BOTTOM = 2;
  localparam int unsigned SIDE_TOP    = 3;

  // Word carried down the pipeline
  typedef struct packed {
    logic                  ep;
    logic                  hit;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [QW-1:0]  q_left;
    logic signed [QW-1:0]  q_right;
    logic signed [QW-1:0]  q_bottom;
    logic signed [QW-1:0]  q_top;
    logic [MW-1:0]         t0n;
    logic [MW-1:0]         t0d;
    logic [MW-1:0]         t1n;
    logic [MW-1:0]         t1d;
  } seg_t;

endpackage

/* hw/rtl/segment_box_intersect_test.sv */
// Top level: box registers, setup stage and four clip steps of the segment/box test.
//
// Tests a 2D segment (two signed fixed-point endpoints) against an inclusive
// screen rectangle held in four registers: box_left, box_bottom, box_right,
// box_top (indexes 0..3 on the cfg_ channel, whole pixels). A cfg word is taken
// when cfg_valid and cfg_ready are high; unknown indexes are dropped. Write the
// box only while no segment is in flight.
//
// Input: a segment word is taken at each clock edge with start high and busy
// low. busy is low outside reset, so one segment may enter every cycle.
// Output: out_valid strobes for one cycle with out_hit and out_endpoint_inside,
// after the setup and clip stage registers, in input order. The depth is
// one setup stage plus a product stage and a compare stage for each of the four
// rectangle sides; the throughput is one segment per cycle.
// The receiver cannot stall, so results are never held back.
//
// Reset (rst_n low, synchronous): box registers clear to zero, in-flight
// segments are dropped, and busy and cfg_ready stay high/low respectively so
// nothing is taken during reset.
module segment_box_intersect_test #(
  parameter int unsigned COORD_FRACTION_BITS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // segment input
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [sbit_pkg::COORD_W-1:0]   in_start_x,
  input  logic signed [sbit_pkg::COORD_W-1:0]   in_start_y,
  input  logic signed [sbit_pkg::COORD_W-1:0]   in_end_x,
  input  logic signed [sbit_pkg::COORD_W-1:0]   in_end_y,
  // result
  output logic                                  out_valid,
  output logic                                  out_hit,
  output logic                                  out_endpoint_inside,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sbit_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sbit_pkg::BOX_W-1:0]            cfg_data
);
  import sbit_pkg::*;

  logic [BOX_W-1:0] box_left_r, box_bottom_r, box_right_r, box_top_r;
  logic [STEPS:0]   chain_valid;
  seg_t             chain_seg [STEPS+1];

  assign busy      = !rst_n;
  assign cfg_ready = rst_n;

  // Box registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_left_r   <= '0;
      box_bottom_r <= '0;
      box_right_r  <= '0;
      box_top_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOX_LEFT:   box_left_r   <= cfg_data;
        REG_BOX_BOTTOM: box_bottom_r <= cfg_data;
        REG_BOX_RIGHT:  box_right_r  <= cfg_data;
        REG_BOX_TOP:    box_top_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Setup stage
  sbit_setup #(
    .COORD_FRACTION_BITS(COORD_FRACTION_BITS)
  ) u_setup (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start && !busy),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .box_left   (box_left_r),
    .box_bottom (box_bottom_r),
    .box_right  (box_right_r),
    .box_top    (box_top_r),
    .out_valid  (chain_valid[0]),
    .out_seg    (chain_seg[0])
  );

  // Clip steps: left, right, bottom, top
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    sbit_step #(
      .SIDE(s)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[s]),
      .in_seg    (chain_seg[s]),
      .out_valid (chain_valid[s+1]),
      .out_seg   (chain_seg[s+1])
    );
  end

  // Result word; an endpoint inside always hits
  assign out_valid           = chain_valid[STEPS];
  assign out_hit             = chain_seg[STEPS].ep || chain_seg[STEPS].hit;
  assign out_endpoint_inside = chain_seg[STEPS].ep;

endmodule

/* hw/rtl/sbit_setup.sv */
// Setup stage: endpoint-inside test, segment deltas and slab offsets.
module sbit_setup #(
  parameter int unsigned COORD_FRACTION_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [sbit_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [sbit_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [sbit_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [sbit_pkg::COORD_W-1:0] in_end_y,
  input  logic [sbit_pkg::BOX_W-1:0]          box_left,
  input  logic [sbit_pkg::BOX_W-1:0]          box_bottom,
  input  logic [sbit_pkg::BOX_W-1:0]          box_right,
  input  logic [sbit_pkg::BOX_W-1:0]          box_top,
  output logic                                out_valid,
  output sbit_pkg::seg_t                      out_seg
);
  import sbit_pkg::*;

  logic [EDGE_W-1:0]    edge_l, edge_b, edge_r, edge_t;
  logic signed [QW-1:0] x0_w, y0_w, x1_w, y1_w;
  logic signed [QW-1:0] xl_w, yb_w, xr_w, yt_w;
  logic                 inside0, inside1;
  seg_t                 seg_nxt;
  logic                 valid_r;
  seg_t                 seg_r;

  // Box edges scaled into the coordinate format
  assign edge_l = EDGE_W'(box_left)   << COORD_FRACTION_BITS;
  assign edge_b = EDGE_W'(box_bottom) << COORD_FRACTION_BITS;
  assign edge_r = EDGE_W'(box_right)  << COORD_FRACTION_BITS;
  assign edge_t = EDGE_W'(box_top)    << COORD_FRACTION_BITS;

  // Everything compared in one common signed width
  assign x0_w = QW'(in_start_x);
  assign y0_w = QW'(in_start_y);
  assign x1_w = QW'(in_end_x);
  assign y1_w = QW'(in_end_y);
  assign xl_w = QW'(edge_l);
  assign yb_w = QW'(edge_b);
  assign xr_w = QW'(edge_r);
  assign yt_w = QW'(edge_t);

  // Inclusive inside tests for both endpoints
  assign inside0 = (x0_w >= xl_w) && (x0_w <= xr_w) && (y0_w >= yb_w) && (y0_w <= yt_w);
  assign inside1 = (x1_w >= xl_w) && (x1_w <= xr_w) && (y1_w >= yb_w) && (y1_w <= yt_w);

  // Initial parameter window [0/1, 1/1]
  always_comb begin
    seg_nxt.ep       = inside0 || inside1;
    seg_nxt.hit      = 1'b1;
    seg_nxt.dx       = DW'(in_end_x) - DW'(in_start_x);
    seg_nxt.dy       = DW'(in_end_y) - DW'(in_start_y);
    seg_nxt.q_left   = x0_w - xl_w;
    seg_nxt.q_right  = xr_w - x0_w;
    seg_nxt.q_bottom = y0_w - yb_w;
    seg_nxt.q_top    = yt_w - y0_w;
    seg_nxt.t0n      = '0;
    seg_nxt.t0d      = MW'(1);
    seg_nxt.t1n      = MW'(1);
    seg_nxt.t1d      = MW'(1);
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign out_valid = valid_r;
  assign out_seg   = seg_r;

endmodule

/* hw/rtl/sbit_step.sv */
// One Liang-Barsky clip step: cross products, then window compare and update.
module sbit_step #(
  parameter int unsigned SIDE = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  sbit_pkg::seg_t in_seg,
  output logic           out_valid,
  output sbit_pkg::seg_t out_seg
);
  import sbit_pkg::*;

  logic signed [DW-1:0] p;
  logic signed [DW-1:0] rd_full;
  logic signed [QW-1:0] q;
  logic signed [QW-1:0] rn;
  logic [MW-1:0]        rd;
  logic                 p_neg;
  logic signed [PW-1:0] prod_a, prod_b, prod_c, prod_d;

  logic                 mid_valid_r;
  seg_t                 mid_seg_r;
  logic signed [QW-1:0] rn_r;
  logic [MW-1:0]        rd_r;
  logic                 p_zero_r, p_neg_r, q_neg_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r;

  seg_t                 seg_nxt;
  logic                 out_valid_r;
  seg_t                 out_seg_r;

  // Direction and offset for this side
  always_comb begin
    unique case (SIDE)
      SIDE_LEFT: begin
        p = -in_seg.dx;
        q = in_seg.q_left;
      end
      SIDE_RIGHT: begin
        p = in_seg.dx;
        q = in_seg.q_right;
      end
      SIDE_BOTTOM: begin
        p = -in_seg.dy;
        q = in_seg.q_bottom;
      end
      SIDE_TOP: begin
        p = in_seg.dy;
        q = in_seg.q_top;
      end
      default: begin
        p = '0;
        q = '0;
      end
    endcase
  end

  // Ratio q/p with a non-negative denominator
  assign p_neg   = p[DW-1];
  assign rn      = p_neg ? -q : q;
  assign rd_full = p_neg ? -p : p;
  assign rd      = rd_full[MW-1:0];

  // Cross products against both window bounds
  assign prod_a = rn * $signed({1'b0, in_seg.t1d});
  assign prod_b = $signed({1'b0, in_seg.t1n}) * $signed({1'b0, rd});
  assign prod_c = rn * $signed({1'b0, in_seg.t0d});
  assign prod_d = $signed({1'b0, in_seg.t0n}) * $signed({1'b0, rd});

  // Product stage: valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else begin
      mid_valid_r <= in_valid;
    end
  end

  // Product stage: payload
  always_ff @(posedge clk) begin
    mid_seg_r <= in_seg;
    rn_r      <= rn;
    rd_r      <= rd;
    p_zero_r  <= (p == '0);
    p_neg_r   <= p_neg;
    q_neg_r   <= q[QW-1];
    pa_r      <= prod_a;
    pb_r      <= prod_b;
    pc_r      <= prod_c;
    pd_r      <= prod_d;
  end

  // Window update: entering ratios raise t0, leaving ratios lower t1, an empty window misses
  always_comb begin
    seg_nxt = mid_seg_r;
    if (mid_seg_r.hit) begin
      if (p_zero_r) begin
        // parallel to this side: outside the slab misses
        if (q_neg_r) begin
          seg_nxt.hit = 1'b0;
        end
      end else if (p_neg_r) begin
        if (pa_r > pb_r) begin
          seg_nxt.hit = 1'b0;
        end else if (pc_r > pd_r) begin
          seg_nxt.t0n = rn_r[MW-1:0];
          seg_nxt.t0d = rd_r;
        end
      end else begin
        if (pd_r > pc_r) begin
          seg_nxt.hit = 1'b0;
        end else if (pb_r > pa_r) begin
          seg_nxt.t1n = rn_r[MW-1:0];
          seg_nxt.t1d = rd_r;
        end
      end
    end
  end

  // Compare stage: valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mid_valid_r;
    end
  end

  // Compare stage: payload
  always_ff @(posedge clk) begin
    out_seg_r <= seg_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_seg   = out_seg_r;

endmodule

/* hw/rtl/sbit_checker.sv */
// Port-level checks for the segment/box test, bound to the top level.
module sbit_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_hit,
  input logic out_endpoint_inside
);
  import sbit_pkg::*;

  // Every taken segment gives a result after the pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("taken segment gave no result at the expected cycle");

  // No result without a segment taken the pipeline depth earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching segment");

  // An endpoint inside the box is a hit
  a_inside_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_endpoint_inside) |-> out_hit)
    else $error("endpoint inside reported without a hit");

  // Reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind segment_box_intersect_test sbit_checker u_sbit_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_hit             (out_hit),
  .out_endpoint_inside (out_endpoint_inside)
);
